/* hw/rtl/sks_pkg.sv */
// Shared constants, codes and types for the searchable key store.
`default_nettype none

package sks_pkg;

    // Store geometry
    localparam int DEPTH  = 1024;
    localparam int KEY_W  = 32;
    localparam int ADDR_W = $clog2(DEPTH);

    // Fixed field widths
    localparam int CNT_W      = 11;
    localparam int POS_W      = 11;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FWD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BWD   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_BIN   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER = 2'd2;

    // Compare unit status
    typedef struct packed {
        logic equal;
        logic less;
    } cmp_t;

endpackage

`default_nettype wire

/* hw/rtl/sks_key_ram.sv */
// Key storage: one write port, one read port with registered read data.
`default_nettype none

module sks_key_ram (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [sks_pkg::ADDR_W-1:0] waddr,
    input  wire logic [sks_pkg::KEY_W-1:0]  wdata,
    input  wire logic [sks_pkg::ADDR_W-1:0] raddr,
    output logic      [sks_pkg::KEY_W-1:0]  rdata
);

    logic [sks_pkg::KEY_W-1:0] mem [sks_pkg::DEPTH];

    // Write one word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read one word, registered
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/sks_key_cmp.sv */
// Shared compare unit: masked equality and masked signed/unsigned less-than.
`default_nettype none

module sks_key_cmp (
    input  wire logic [sks_pkg::KEY_W-1:0] entry,
    input  wire logic [sks_pkg::KEY_W-1:0] key,
    input  wire logic [sks_pkg::KEY_W-1:0] mask,
    input  wire logic                      signed_order,
    output sks_pkg::cmp_t                  result
);

    logic [sks_pkg::KEY_W-1:0] entry_m;
    logic [sks_pkg::KEY_W-1:0] key_m;
    logic [sks_pkg::KEY_W-1:0] flip;

    // Flip the sign bit so that an unsigned compare gives two's complement order
    assign flip    = {signed_order, {(sks_pkg::KEY_W-1){1'b0}}};
    assign entry_m = (entry & mask) ^ flip;
    assign key_m   = (key & mask) ^ flip;

    assign result.equal = ((entry ^ key) & mask) == '0;
    assign result.less  = entry_m < key_m;

endmodule

`default_nettype wire

/* hw/rtl/searchable_key_store.sv */
// Top level of the searchable key store: config registers, sequencer, results.
//
//  Channel   Ports                              Handshake
//  --------  ---------------------------------  ------------------------------
//  command   start, busy, command, position,    taken when start && !busy
//            key
//  result    done, found, match_index           one-cycle strobe on done
//  config    cfg_we, cfg_index, cfg_data        written when cfg_we is high
//
// A write enters the RAM when it is taken; its result strobes on the next cycle.
// Forward and backward finds read one entry at a time through the single RAM
// read port and compare unit, passing through ST_ADDR and ST_EVAL per entry.
// Binary search halves the range per probe (ST_ADDR, then ST_EVAL on the
// registered RAM data) and checks any remaining candidate in ST_TAIL.
// Reset clears the configuration to its defaults and the sequencer to idle; the
// store itself holds no reset value. The receiver cannot stall results.
`default_nettype none

module searchable_key_store (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [sks_pkg::CMD_W-1:0]      command,
    input  wire logic [sks_pkg::POS_W-1:0]      position,
    input  wire logic [sks_pkg::KEY_W-1:0]      key,
    output logic                               done,
    output logic                               found,
    output logic      [sks_pkg::ADDR_W-1:0]     match_index,
    input  wire logic                          cfg_we,
    input  wire logic [sks_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sks_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = sks_pkg::ADDR_W;
    localparam int CW = sks_pkg::CNT_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ADDR = 4'b0010,
        ST_EVAL = 4'b0100,
        ST_TAIL = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    logic [sks_pkg::CMD_W-1:0]  cmd_reg, cmd_next;
    logic [sks_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic [CW-1:0]              hi_reg, hi_next;
    logic [AW-1:0]              mid_reg, mid_next;
    logic                       done_reg, done_next;
    logic                       found_reg, found_next;
    logic [AW-1:0]              mi_reg, mi_next;

    logic [CW-1:0]              count_reg;
    logic [sks_pkg::KEY_W-1:0]  mask_reg;
    logic                       order_reg;

    logic [CW-1:0]              len;
    logic [CW-1:0]              dec;
    logic [CW-1:0]              probe;
    logic [AW-1:0]              rd_addr;
    logic                       wr_en;
    logic [sks_pkg::KEY_W-1:0]  rd_data;
    sks_pkg::cmp_t              cmp;

    // Entries in use, capped at the store depth
    assign len   = (count_reg > CW'(sks_pkg::DEPTH)) ? CW'(sks_pkg::DEPTH) : count_reg;
    assign dec   = idx_reg - CW'(1);
    assign probe = idx_reg + ((hi_reg - idx_reg) >> 1);

    sks_key_ram u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (position[AW-1:0]),
        .wdata (key),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    sks_key_cmp u_cmp (
        .entry        (rd_data),
        .key          (key_reg),
        .mask         (mask_reg),
        .signed_order (order_reg),
        .result       (cmp)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            mask_reg  <= '1;
            order_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sks_pkg::REG_COUNT: count_reg <= cfg_data[CW-1:0];
                sks_pkg::REG_MASK:  mask_reg  <= cfg_data[sks_pkg::KEY_W-1:0];
                sks_pkg::REG_ORDER: order_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer: write a key from idle; for searches pick the next entry, read it, judge it
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        done_next  = 1'b0;
        found_next = 1'b0;
        mi_next    = '0;
        rd_addr    = mid_reg;
        wr_en      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = command;
                    key_next = key;
                    unique case (command)
                        sks_pkg::CMD_WRITE:
                        begin
                            wr_en     = position < CW'(sks_pkg::DEPTH);
                            done_next = 1'b1;
                        end
                        sks_pkg::CMD_FWD:
                        begin
                            idx_next   = position;
                            state_next = ST_ADDR;
                        end
                        sks_pkg::CMD_BWD:
                        begin
                            idx_next   = (position > len) ? len : position;
                            state_next = ST_ADDR;
                        end
                        sks_pkg::CMD_BIN:
                        begin
                            idx_next   = '0;
                            hi_next    = len;
                            state_next = ST_ADDR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_ADDR:
            begin
                unique case (cmd_reg)
                    sks_pkg::CMD_FWD:
                    begin
                        if (idx_reg >= len)
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            rd_addr    = idx_reg[AW-1:0];
                            mid_next   = idx_reg[AW-1:0];
                            state_next = ST_EVAL;
                        end
                    end
                    sks_pkg::CMD_BWD:
                    begin
                        if (idx_reg == '0)
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            idx_next   = dec;
                            rd_addr    = dec[AW-1:0];
                            mid_next   = dec[AW-1:0];
                            state_next = ST_EVAL;
                        end
                    end
                    sks_pkg::CMD_BIN:
                    begin
                        if (idx_reg < hi_reg)
                        begin
                            rd_addr    = probe[AW-1:0];
                            mid_next   = probe[AW-1:0];
                            state_next = ST_EVAL;
                        end
                        else if (idx_reg < len)
                        begin
                            rd_addr    = idx_reg[AW-1:0];
                            mid_next   = idx_reg[AW-1:0];
                            state_next = ST_TAIL;
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_EVAL:
            begin
                unique case (cmd_reg)
                    sks_pkg::CMD_FWD,
                    sks_pkg::CMD_BWD:
                    begin
                        if (cmp.equal)
                        begin
                            done_next  = 1'b1;
                            found_next = 1'b1;
                            mi_next    = mid_reg;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            if (cmd_reg == sks_pkg::CMD_FWD)
                            begin
                                idx_next = idx_reg + CW'(1);
                            end
                            state_next = ST_ADDR;
                        end
                    end
                    sks_pkg::CMD_BIN:
                    begin
                        if (cmp.less)
                        begin
                            idx_next = {1'b0, mid_reg} + CW'(1);
                        end
                        else
                        begin
                            hi_next = {1'b0, mid_reg};
                        end
                        state_next = ST_ADDR;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_TAIL:
            begin
                done_next  = 1'b1;
                found_next = cmp.equal;
                mi_next    = cmp.equal ? mid_reg : '0;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Working registers and result word
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        key_reg   <= key_next;
        idx_reg   <= idx_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        found_reg <= found_next;
        mi_reg    <= mi_next;
    end

    assign busy        = state_reg != ST_IDLE;
    assign done        = done_reg;
    assign found       = found_reg;
    assign match_index = mi_reg;

    // A hit is only reported together with the strobe
    assert property (@(posedge clk) disable iff (!rst_n) found |-> done)
        else $error("found raised without done");

    // A reported hit lies inside the entries in use
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> ({1'b0, match_index} < len))
        else $error("match index beyond entries in use");

    // Only an accepted search makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && command != sks_pkg::CMD_WRITE))
        else $error("busy rose without a search command");

    // Every result word comes from a search in flight or a write just taken
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start && command == sks_pkg::CMD_WRITE)))
        else $error("result word without a command");

endmodule

`default_nettype wire
